// ===== rtl/core/tbb_pkg.sv =====
// Shared types, register indexes and saturation helpers for the box bounds pipeline.
package tbb_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned BIAS_W = 31;

  typedef logic signed [QW-1:0]   q_t;
  typedef logic signed [2*QW-1:0] prod_t;
  typedef logic signed [47:0]     wide_t;

  // bounds: [0]=x_min [1]=x_max [2]=y_min [3]=y_max [4]=z_min [5]=z_max
  typedef q_t [5:0] bounds_t;
  // products indexed [out axis][in axis][endpoint: 0=min bound, 1=max bound]
  typedef prod_t [2:0][2:0][1:0] prods_t;
  // coefficients indexed [out axis][in axis]
  typedef q_t [2:0][2:0] coefs_t;
  typedef q_t [2:0][2:0] terms_t;
  typedef q_t [2:0]      trans_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_BIAS = 3'd6;

  // reset values: identity rotation, zero translation, bias of about 0.01
  localparam logic [CFG_DATA_W-1:0] ROW_X_LO_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_X_HI_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Y_LO_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Y_HI_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Z_LO_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Z_HI_RST = 64'h0000_0000_0001_0000;
  localparam logic [BIAS_W-1:0]     BIAS_RST     = 31'd655;

  localparam wide_t WIDE_QMAX = 48'sh0000_7FFF_FFFF;
  localparam wide_t WIDE_QMIN = -48'sh0000_8000_0000;

  function automatic q_t sat_q(input wide_t v);
    q_t r;
    if (v > WIDE_QMAX) begin
      r = q_t'(WIDE_QMAX);
    end else if (v < WIDE_QMIN) begin
      r = q_t'(WIDE_QMIN);
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic wide_t ext_q(input q_t v);
    return wide_t'({{16{v[QW-1]}}, v});
  endfunction

endpackage

// ===== rtl/core/transformed_box_bounds.sv =====
// Pipeline: 4 register stages; widen, multiply, floor/min-max, sum each take one stage.
// Throughput: one box per cycle while out_ready does not stall the pipeline.
// Each stage holds its beat while the next is stalled and fills bubbles on its own.
// Reset: pipeline valids clear; matrix rows return to identity, bias to 655.
// Results come from the top three matrix rows; the w row is not stored.
module transformed_box_bounds (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_x_min,
  input  logic signed [31:0]                 in_x_max,
  input  logic signed [31:0]                 in_y_min,
  input  logic signed [31:0]                 in_y_max,
  input  logic signed [31:0]                 in_z_min,
  input  logic signed [31:0]                 in_z_max,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_x_min,
  output logic signed [31:0]                 out_x_max,
  output logic signed [31:0]                 out_y_min,
  output logic signed [31:0]                 out_y_max,
  output logic signed [31:0]                 out_z_min,
  output logic signed [31:0]                 out_z_max,
  input  logic                               cfg_we,
  input  logic [tbb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [tbb_pkg::CFG_DATA_W-1:0] row_x_lo;
  logic [tbb_pkg::CFG_DATA_W-1:0] row_x_hi;
  logic [tbb_pkg::CFG_DATA_W-1:0] row_y_lo;
  logic [tbb_pkg::CFG_DATA_W-1:0] row_y_hi;
  logic [tbb_pkg::CFG_DATA_W-1:0] row_z_lo;
  logic [tbb_pkg::CFG_DATA_W-1:0] row_z_hi;
  logic [tbb_pkg::BIAS_W-1:0]     flat_bias;

  tbb_pkg::bounds_t in_bounds;
  tbb_pkg::bounds_t wid_bounds;
  tbb_pkg::bounds_t res_bounds;
  tbb_pkg::prods_t  prods;
  tbb_pkg::terms_t  terms_lo;
  tbb_pkg::terms_t  terms_hi;
  tbb_pkg::coefs_t  coefs;
  tbb_pkg::trans_t  trans;

  logic wid_valid, wid_ready;
  logic mul_valid, mul_ready;
  logic rng_valid, rng_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_lo  <= tbb_pkg::ROW_X_LO_RST;
      row_x_hi  <= tbb_pkg::ROW_X_HI_RST;
      row_y_lo  <= tbb_pkg::ROW_Y_LO_RST;
      row_y_hi  <= tbb_pkg::ROW_Y_HI_RST;
      row_z_lo  <= tbb_pkg::ROW_Z_LO_RST;
      row_z_hi  <= tbb_pkg::ROW_Z_HI_RST;
      flat_bias <= tbb_pkg::BIAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tbb_pkg::CFG_ROW_X_LO:  row_x_lo  <= cfg_data;
        tbb_pkg::CFG_ROW_X_HI:  row_x_hi  <= cfg_data;
        tbb_pkg::CFG_ROW_Y_LO:  row_y_lo  <= cfg_data;
        tbb_pkg::CFG_ROW_Y_HI:  row_y_hi  <= cfg_data;
        tbb_pkg::CFG_ROW_Z_LO:  row_z_lo  <= cfg_data;
        tbb_pkg::CFG_ROW_Z_HI:  row_z_hi  <= cfg_data;
        tbb_pkg::CFG_FLAT_BIAS: flat_bias <= cfg_data[tbb_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coefs[0][0] = row_x_lo[31:0];
    coefs[0][1] = row_x_lo[63:32];
    coefs[0][2] = row_x_hi[31:0];
    coefs[1][0] = row_y_lo[31:0];
    coefs[1][1] = row_y_lo[63:32];
    coefs[1][2] = row_y_hi[31:0];
    coefs[2][0] = row_z_lo[31:0];
    coefs[2][1] = row_z_lo[63:32];
    coefs[2][2] = row_z_hi[31:0];
    trans[0]    = row_x_hi[63:32];
    trans[1]    = row_y_hi[63:32];
    trans[2]    = row_z_hi[63:32];
  end

  assign in_bounds[0] = in_x_min;
  assign in_bounds[1] = in_x_max;
  assign in_bounds[2] = in_y_min;
  assign in_bounds[3] = in_y_max;
  assign in_bounds[4] = in_z_min;
  assign in_bounds[5] = in_z_max;

  tbb_widen u_widen (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_bounds  (in_bounds),
    .bias       (flat_bias),
    .out_valid  (wid_valid),
    .out_ready  (wid_ready),
    .out_bounds (wid_bounds)
  );

  tbb_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wid_valid),
    .in_ready  (wid_ready),
    .in_bounds (wid_bounds),
    .coefs     (coefs),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_prods (prods)
  );

  tbb_range u_range (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_prods  (prods),
    .out_valid (rng_valid),
    .out_ready (rng_ready),
    .out_lo    (terms_lo),
    .out_hi    (terms_hi)
  );

  tbb_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rng_valid),
    .in_ready   (rng_ready),
    .in_lo      (terms_lo),
    .in_hi      (terms_hi),
    .trans      (trans),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bounds (res_bounds)
  );

  assign out_x_min = res_bounds[0];
  assign out_x_max = res_bounds[1];
  assign out_y_min = res_bounds[2];
  assign out_y_max = res_bounds[3];
  assign out_z_min = res_bounds[4];
  assign out_z_max = res_bounds[5];

  // extremes of the corner set can never cross
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_x_min <= out_x_max) && (out_y_min <= out_y_max)
                  && (out_z_min <= out_z_max))
    else $error("result min exceeds max");

  // back-pressure reaches the input only when every stage holds a beat
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> wid_valid && mul_valid && rng_valid && out_valid && !out_ready)
    else $error("input stalled with a free stage");

  assert property (@(posedge clk) rst |=> !out_valid && !wid_valid && !mul_valid && !rng_valid)
    else $error("pipeline valid after reset");

  // a beat taken from a full pipeline frees the input in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("input not ready while output drains");

endmodule

// ===== rtl/core/tbb_widen.sv =====
// Stage 1: widens flat axes by the bias, saturating each bound.
module tbb_widen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tbb_pkg::bounds_t                   in_bounds,
  input  logic [tbb_pkg::BIAS_W-1:0]         bias,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tbb_pkg::bounds_t                   out_bounds
);

  tbb_pkg::bounds_t bounds_next;
  logic             valid;
  tbb_pkg::bounds_t bounds;

  always_comb begin
    logic signed [32:0] diff;
    logic [32:0]        extent;
    tbb_pkg::wide_t     bias_w;
    bias_w = tbb_pkg::wide_t'({17'd0, bias});
    for (int j = 0; j < 3; j++) begin
      diff = $signed({in_bounds[2*j+1][31], in_bounds[2*j+1]})
           - $signed({in_bounds[2*j][31], in_bounds[2*j]});
      extent = diff[32] ? 33'(-diff) : 33'(diff);
      if (extent < {2'b00, bias}) begin
        bounds_next[2*j]   = tbb_pkg::sat_q(tbb_pkg::ext_q(in_bounds[2*j]) - bias_w);
        bounds_next[2*j+1] = tbb_pkg::sat_q(tbb_pkg::ext_q(in_bounds[2*j+1]) + bias_w);
      end else begin
        bounds_next[2*j]   = in_bounds[2*j];
        bounds_next[2*j+1] = in_bounds[2*j+1];
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bounds <= bounds_next;
    end
  end

  assign out_valid  = valid;
  assign out_bounds = bounds;

endmodule

// ===== rtl/core/tbb_mul.sv =====
// Stage 2: each coefficient times both bounds of its input axis, full Q32.32 products.
module tbb_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tbb_pkg::bounds_t in_bounds,
  input  tbb_pkg::coefs_t  coefs,
  output logic             out_valid,
  input  logic             out_ready,
  output tbb_pkg::prods_t  out_prods
);

  tbb_pkg::prods_t prods_next;
  tbb_pkg::prods_t prods;
  logic            valid;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        for (int e = 0; e < 2; e++) begin
          prods_next[a][j][e] = $signed(coefs[a][j]) * $signed(in_bounds[2*j+e]);
        end
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prods <= prods_next;
    end
  end

  assign out_valid = valid;
  assign out_prods = prods;

endmodule

// ===== rtl/core/tbb_range.sv =====
// Stage 3: floors and saturates products, keeps the smaller and larger term per pair.
module tbb_range (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tbb_pkg::prods_t in_prods,
  output logic            out_valid,
  input  logic            out_ready,
  output tbb_pkg::terms_t out_lo,
  output tbb_pkg::terms_t out_hi
);

  tbb_pkg::terms_t lo_next;
  tbb_pkg::terms_t hi_next;
  tbb_pkg::terms_t lo;
  tbb_pkg::terms_t hi;
  logic            valid;

  // floor and saturation are monotonic, so per-term min/max gives the corner extremes
  always_comb begin
    tbb_pkg::q_t t0;
    tbb_pkg::q_t t1;
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        t0 = tbb_pkg::sat_q(tbb_pkg::wide_t'(in_prods[a][j][0] >>> 16));
        t1 = tbb_pkg::sat_q(tbb_pkg::wide_t'(in_prods[a][j][1] >>> 16));
        if ($signed(t0) < $signed(t1)) begin
          lo_next[a][j] = t0;
          hi_next[a][j] = t1;
        end else begin
          lo_next[a][j] = t1;
          hi_next[a][j] = t0;
        end
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  assign out_valid = valid;
  assign out_lo    = lo;
  assign out_hi    = hi;

endmodule

// ===== rtl/core/tbb_sum.sv =====
// Stage 4: adds terms and translation per axis, saturates, holds the result beat.
module tbb_sum (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tbb_pkg::terms_t  in_lo,
  input  tbb_pkg::terms_t  in_hi,
  input  tbb_pkg::trans_t  trans,
  output logic             out_valid,
  input  logic             out_ready,
  output tbb_pkg::bounds_t out_bounds
);

  tbb_pkg::bounds_t bounds_next;
  tbb_pkg::bounds_t bounds;
  logic             valid;

  always_comb begin
    tbb_pkg::wide_t s_lo;
    tbb_pkg::wide_t s_hi;
    for (int a = 0; a < 3; a++) begin
      s_lo = tbb_pkg::ext_q(in_lo[a][0]) + tbb_pkg::ext_q(in_lo[a][1])
           + tbb_pkg::ext_q(in_lo[a][2]) + tbb_pkg::ext_q(trans[a]);
      s_hi = tbb_pkg::ext_q(in_hi[a][0]) + tbb_pkg::ext_q(in_hi[a][1])
           + tbb_pkg::ext_q(in_hi[a][2]) + tbb_pkg::ext_q(trans[a]);
      bounds_next[2*a]   = tbb_pkg::sat_q(s_lo);
      bounds_next[2*a+1] = tbb_pkg::sat_q(s_hi);
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bounds <= bounds_next;
    end
  end

  assign out_valid  = valid;
  assign out_bounds = bounds;

endmodule
